>>> hw/rtl/trdt_pkg.sv
// shared types and constants of the triangle raster depth test core
package trdt_pkg;

   // screen and depth store geometry
   localparam int unsigned PIX_W      = 8;
   localparam int unsigned ADDR_W     = 2 * PIX_W;
   localparam int unsigned STORE_SIZE = 1 << ADDR_W;
   localparam int unsigned DEPTH_W    = 16;

   // fixed-point constants
   localparam logic signed [DEPTH_W-1:0] DEPTH_FLOOR = 16'sh8000;
   localparam logic [16:0]               WEIGHT_ONE  = 17'h10000;
   localparam logic signed [27:0]        MIN_AREA    = 28'sd256;

   // request function codes
   localparam logic FUNC_LOAD = 1'b0;
   localparam logic FUNC_STEP = 1'b1;

   // request beat
   typedef struct packed {
      logic               func;
      logic [11:0]        vertex_x0;
      logic [11:0]        vertex_y0;
      logic signed [15:0] vertex_z0;
      logic [11:0]        vertex_x1;
      logic [11:0]        vertex_y1;
      logic signed [15:0] vertex_z1;
      logic [11:0]        vertex_x2;
      logic [11:0]        vertex_y2;
      logic signed [15:0] vertex_z2;
      logic [7:0]         shade;
   } req_type;

   // response beat
   typedef struct packed {
      logic       write_pixel;
      logic [7:0] pixel_x;
      logic [7:0] pixel_y;
      logic [7:0] pixel_shade;
      logic       scan_done;
   } rsp_type;

   // sequencer states
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CROSS,
      ST_DSETUP,
      ST_DITER,
      ST_DEPTH,
      ST_TEST,
      ST_RESP
   } state_type;

endpackage

>>> hw/rtl/trdt_ram.sv
// generic single write port ram with registered read
module trdt_ram #(
   parameter int unsigned WIDTH = 16,
   parameter int unsigned DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/triangle_raster_depth_test_core.sv
// top level of the flat-shaded triangle rasterizer with depth store
//
// Usage: a request beat with func load latches three 8.4 vertices, depths
// and a shade and sets up the pixel box; each request beat with func step
// visits the next box pixel in row order and gives one response beat with
// the pixel, its shade, a write flag and a last-pixel flag. Every request
// gives exactly one response. The csr channel writes the depth test
// enable bit and is always ready; write it only while the core is idle.
// Flow: a load or an idle step passes the response state into the response
// register, and the next request is taken in the cycle that it appears.
// A covered step forms the cross products on the shared multiplier, runs
// three divisions on one shared divider, each a setup state and up to 16
// restoring quotient bits, sums three depth products, compares with and
// may update the depth store and moves the beat into the response register.
// A degenerate triangle answers after the cross products; a pixel outside the
// triangle ends early, after the first failing test.
// One item is in flight at a time; req_stall is high while it is worked.
// Reset: the depth store is cleared, all 65536 entries, to the most negative
// depth, one entry a cycle, with req_stall high; csr writes are taken meanwhile.
// The response register holds its beat while rsp_stall is high; a new
// request is accepted then, and its result waits until the beat is taken.
module triangle_raster_depth_test_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  trdt_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output trdt_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              csr_data
);

   // control state
   trdt_pkg::state_type state_ff, state_in;
   logic dte_ff, dte_in;
   logic active_ff, active_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [trdt_pkg::ADDR_W-1:0] clr_ff, clr_in;
   logic [2:0] step_ff, step_in;
   logic [1:0] dsel_ff, dsel_in;
   logic [4:0] bit_ff, bit_in;

   // triangle and scan state
   logic [11:0] vx_ff [3];
   logic [11:0] vx_in [3];
   logic [11:0] vy_ff [3];
   logic [11:0] vy_in [3];
   logic signed [15:0] vz_ff [3];
   logic signed [15:0] vz_in [3];
   logic [7:0] shade_ff, shade_in;
   logic [7:0] bx0_ff, bx0_in, by0_ff, by0_in, bx1_ff, bx1_in, by1_ff, by1_in;
   logic [7:0] col_ff, col_in, row_ff, row_in;
   logic [7:0] px_ff, px_in, py_ff, py_in;

   // arithmetic registers
   logic signed [35:0] prod_ff, prod_in;
   logic signed [27:0] a_ff, a_in, eu_ff, eu_in, ev_ff, ev_in;
   logic [27:0] rem_ff, rem_in, dvs_ff, dvs_in;
   logic [15:0] q_ff, q_in;
   logic neg_ff, neg_in;
   logic [16:0] u_ff, u_in, v_ff, v_in, w_ff, w_in;
   logic signed [35:0] zacc_ff, zacc_in;
   trdt_pkg::rsp_type pend_ff, pend_in, rsp_ff, rsp_in;

   // combinational helpers
   logic accept;
   logic signed [12:0] dx1, dy1, dx2, dy2, ox, oy;
   logic signed [17:0] mul_a, mul_b;
   logic signed [27:0] e_sel;
   logic [27:0] n_mag, a_mag, rem2;
   logic fin_en;
   logic [16:0] fin_q;
   logic signed [19:0] zf;
   logic signed [15:0] z_new;
   logic [11:0] min_x, min_y, max_x, max_y;

   // depth store ports
   logic mem_we, mem_re;
   logic [trdt_pkg::ADDR_W-1:0] mem_waddr;
   logic [trdt_pkg::DEPTH_W-1:0] mem_wdata, mem_rdata;

   trdt_ram #(
      .WIDTH(trdt_pkg::DEPTH_W),
      .DEPTH(trdt_pkg::STORE_SIZE)
   ) u_store (
      .clock  (clock),
      .wr_en  (mem_we),
      .wr_addr(mem_waddr),
      .wr_data(mem_wdata),
      .rd_en  (mem_re),
      .rd_addr({row_ff, col_ff}),
      .rd_data(mem_rdata)
   );

   // vertex differences and pixel offsets
   assign dx1 = $signed({1'b0, vx_ff[1]}) - $signed({1'b0, vx_ff[0]});
   assign dy1 = $signed({1'b0, vy_ff[1]}) - $signed({1'b0, vy_ff[0]});
   assign dx2 = $signed({1'b0, vx_ff[2]}) - $signed({1'b0, vx_ff[0]});
   assign dy2 = $signed({1'b0, vy_ff[2]}) - $signed({1'b0, vy_ff[0]});
   assign ox  = $signed({1'b0, vx_ff[0]}) - $signed({1'b0, px_ff, 4'b0000});
   assign oy  = $signed({1'b0, vy_ff[0]}) - $signed({1'b0, py_ff, 4'b0000});

   // bounding box of the incoming triangle
   always_comb begin
      min_x = req_data.vertex_x0;
      max_x = req_data.vertex_x0;
      min_y = req_data.vertex_y0;
      max_y = req_data.vertex_y0;
      if (req_data.vertex_x1 < min_x) min_x = req_data.vertex_x1;
      if (req_data.vertex_x2 < min_x) min_x = req_data.vertex_x2;
      if (req_data.vertex_x1 > max_x) max_x = req_data.vertex_x1;
      if (req_data.vertex_x2 > max_x) max_x = req_data.vertex_x2;
      if (req_data.vertex_y1 < min_y) min_y = req_data.vertex_y1;
      if (req_data.vertex_y2 < min_y) min_y = req_data.vertex_y2;
      if (req_data.vertex_y1 > max_y) max_y = req_data.vertex_y1;
      if (req_data.vertex_y2 > max_y) max_y = req_data.vertex_y2;
   end

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      if (state_ff == trdt_pkg::ST_CROSS) begin
         unique case (step_ff)
            3'd0: begin mul_a = 18'(dx1); mul_b = 18'(dy2); end
            3'd1: begin mul_a = 18'(dx2); mul_b = 18'(dy1); end
            3'd2: begin mul_a = 18'(dx2); mul_b = 18'(oy);  end
            3'd3: begin mul_a = 18'(ox);  mul_b = 18'(dy2); end
            3'd4: begin mul_a = 18'(ox);  mul_b = 18'(dy1); end
            3'd5: begin mul_a = 18'(dx1); mul_b = 18'(oy);  end
            default: begin mul_a = '0; mul_b = '0; end
         endcase
      end else if (state_ff == trdt_pkg::ST_DEPTH) begin
         unique case (step_ff)
            3'd0: begin mul_a = 18'(vz_ff[0]); mul_b = $signed({1'b0, w_ff}); end
            3'd1: begin mul_a = 18'(vz_ff[1]); mul_b = $signed({1'b0, u_ff}); end
            3'd2: begin mul_a = 18'(vz_ff[2]); mul_b = $signed({1'b0, v_ff}); end
            default: begin mul_a = '0; mul_b = '0; end
         endcase
      end
   end

   assign prod_in = mul_a * mul_b;

   // divider operands
   always_comb begin
      unique case (dsel_ff)
         2'd0:    e_sel = eu_ff;
         2'd1:    e_sel = ev_ff;
         default: e_sel = eu_ff + ev_ff;
      endcase
   end
   assign n_mag = e_sel[27] ? 28'(-e_sel) : 28'(e_sel);
   assign a_mag = a_ff[27] ? 28'(-a_ff) : 28'(a_ff);
   assign rem2  = {rem_ff[26:0], 1'b0};

   // interpolated depth, floored and saturated
   assign zf = zacc_ff[35:16];
   always_comb begin
      if (zf > 20'sd32767) begin
         z_new = 16'sh7fff;
      end else if (zf < -20'sd32768) begin
         z_new = trdt_pkg::DEPTH_FLOOR;
      end else begin
         z_new = zf[15:0];
      end
   end

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != trdt_pkg::ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // sequencer: next state and datapath control
   always_comb begin
      state_in     = state_ff;
      dte_in       = (csr_valid && csr_ready) ? csr_data : dte_ff;
      active_in    = active_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      clr_in       = clr_ff;
      step_in      = step_ff;
      dsel_in      = dsel_ff;
      bit_in       = bit_ff;
      vx_in        = vx_ff;
      vy_in        = vy_ff;
      vz_in        = vz_ff;
      shade_in     = shade_ff;
      bx0_in       = bx0_ff;
      by0_in       = by0_ff;
      bx1_in       = bx1_ff;
      by1_in       = by1_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      a_in         = a_ff;
      eu_in        = eu_ff;
      ev_in        = ev_ff;
      rem_in       = rem_ff;
      dvs_in       = dvs_ff;
      q_in         = q_ff;
      neg_in       = neg_ff;
      u_in         = u_ff;
      v_in         = v_ff;
      w_in         = w_ff;
      zacc_in      = zacc_ff;
      pend_in      = pend_ff;
      mem_we       = 1'b0;
      mem_waddr    = {py_ff, px_ff};
      mem_wdata    = z_new;
      mem_re       = 1'b0;
      fin_en       = 1'b0;
      fin_q        = '0;

      unique case (state_ff)
         // sweep the depth store after reset
         trdt_pkg::ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = trdt_pkg::DEPTH_FLOOR;
            clr_in    = clr_ff + 1'b1;
            if (&clr_ff) begin
               state_in = trdt_pkg::ST_IDLE;
            end
         end

         // take a request beat
         trdt_pkg::ST_IDLE: begin
            if (accept) begin
               pend_in = '0;
               if (req_data.func == trdt_pkg::FUNC_LOAD) begin
                  vx_in[0] = req_data.vertex_x0;
                  vy_in[0] = req_data.vertex_y0;
                  vz_in[0] = req_data.vertex_z0;
                  vx_in[1] = req_data.vertex_x1;
                  vy_in[1] = req_data.vertex_y1;
                  vz_in[1] = req_data.vertex_z1;
                  vx_in[2] = req_data.vertex_x2;
                  vy_in[2] = req_data.vertex_y2;
                  vz_in[2] = req_data.vertex_z2;
                  shade_in = req_data.shade;
                  bx0_in    = min_x[11:4];
                  by0_in    = min_y[11:4];
                  bx1_in    = max_x[11:4];
                  by1_in    = max_y[11:4];
                  col_in    = min_x[11:4];
                  row_in    = min_y[11:4];
                  active_in = 1'b1;
                  state_in  = trdt_pkg::ST_RESP;
               end else if (!active_ff) begin
                  pend_in.scan_done = 1'b1;
                  state_in          = trdt_pkg::ST_RESP;
               end else begin
                  px_in               = col_ff;
                  py_in               = row_ff;
                  mem_re              = 1'b1;
                  pend_in.pixel_x     = col_ff;
                  pend_in.pixel_y     = row_ff;
                  pend_in.pixel_shade = shade_ff;
                  // advance the scan in row order
                  if (col_ff >= bx1_ff && row_ff >= by1_ff) begin
                     pend_in.scan_done = 1'b1;
                     active_in         = 1'b0;
                  end else if (col_ff >= bx1_ff) begin
                     col_in = bx0_ff;
                     row_in = row_ff + 1'b1;
                  end else begin
                     col_in = col_ff + 1'b1;
                  end
                  step_in  = '0;
                  state_in = trdt_pkg::ST_CROSS;
               end
            end
         end

         // cross products, one product a cycle, each accumulated in the next cycle
         trdt_pkg::ST_CROSS: begin
            step_in = step_ff + 1'b1;
            unique case (step_ff)
               3'd1:    a_in  = prod_ff[27:0];
               3'd2:    a_in  = a_ff - prod_ff[27:0];
               3'd3:    eu_in = prod_ff[27:0];
               3'd4:    eu_in = eu_ff - prod_ff[27:0];
               3'd5:    ev_in = prod_ff[27:0];
               3'd6:    ev_in = ev_ff - prod_ff[27:0];
               default: a_in  = a_ff;
            endcase
            if (step_ff == 3'd6) begin
               dsel_in = '0;
               if (a_ff > -trdt_pkg::MIN_AREA && a_ff < trdt_pkg::MIN_AREA) begin
                  state_in = trdt_pkg::ST_RESP;
               end else begin
                  state_in = trdt_pkg::ST_DSETUP;
               end
            end
         end

         // classify the quotient range before iterating
         trdt_pkg::ST_DSETUP: begin
            dvs_in = a_mag;
            neg_in = e_sel[27] ^ a_ff[27];
            rem_in = n_mag;
            q_in   = '0;
            bit_in = 5'd16;
            if (n_mag == '0) begin
               fin_en = 1'b1;
               fin_q  = '0;
            end else if (n_mag > a_mag) begin
               // a large area lets a small excess still truncate to one
               if (!(e_sel[27] ^ a_ff[27]) &&
                   (n_mag - a_mag) <= ((a_mag - 28'd1) >> 16)) begin
                  fin_en = 1'b1;
                  fin_q  = trdt_pkg::WEIGHT_ONE;
               end else begin
                  state_in = trdt_pkg::ST_RESP;
               end
            end else if (n_mag == a_mag) begin
               if (e_sel[27] ^ a_ff[27]) begin
                  state_in = trdt_pkg::ST_RESP;
               end else begin
                  fin_en = 1'b1;
                  fin_q  = trdt_pkg::WEIGHT_ONE;
               end
            end else begin
               state_in = trdt_pkg::ST_DITER;
            end
         end

         // one restoring quotient bit a cycle
         trdt_pkg::ST_DITER: begin
            if (rem2 >= dvs_ff) begin
               rem_in = rem2 - dvs_ff;
               q_in   = {q_ff[14:0], 1'b1};
            end else begin
               rem_in = rem2;
               q_in   = {q_ff[14:0], 1'b0};
            end
            bit_in = bit_ff - 1'b1;
            if (bit_ff == 5'd1) begin
               if (neg_ff && q_in != '0) begin
                  state_in = trdt_pkg::ST_RESP;
               end else begin
                  fin_en = 1'b1;
                  fin_q  = {1'b0, q_in};
               end
            end
         end

         // depth sum over three products
         trdt_pkg::ST_DEPTH: begin
            step_in = step_ff + 1'b1;
            if (step_ff == 3'd1) begin
               zacc_in = prod_ff;
            end else if (step_ff != 3'd0) begin
               zacc_in = zacc_ff + prod_ff;
            end
            if (step_ff == 3'd3) begin
               state_in = trdt_pkg::ST_TEST;
            end
         end

         // depth compare and store update
         trdt_pkg::ST_TEST: begin
            if (!dte_ff) begin
               pend_in.write_pixel = 1'b1;
            end else if ($signed(mem_rdata) < z_new) begin
               pend_in.write_pixel = 1'b1;
               mem_we              = 1'b1;
            end
            state_in = trdt_pkg::ST_RESP;
         end

         // hand the beat to the output register
         trdt_pkg::ST_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in       = pend_ff;
               rsp_valid_in = 1'b1;
               state_in     = trdt_pkg::ST_IDLE;
            end
         end

         default: state_in = trdt_pkg::ST_IDLE;
      endcase

      // store a finished weight and move to the next division
      if (fin_en) begin
         unique case (dsel_ff)
            2'd0:    u_in = fin_q;
            2'd1:    v_in = fin_q;
            default: w_in = trdt_pkg::WEIGHT_ONE - fin_q;
         endcase
         if (dsel_ff == 2'd2) begin
            step_in  = '0;
            state_in = trdt_pkg::ST_DEPTH;
         end else begin
            dsel_in  = dsel_ff + 1'b1;
            state_in = trdt_pkg::ST_DSETUP;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= trdt_pkg::ST_CLEAR;
         dte_ff       <= 1'b1;
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         clr_ff       <= '0;
         step_ff      <= '0;
         dsel_ff      <= '0;
         bit_ff       <= '0;
         vx_ff        <= '{default: '0};
         vy_ff        <= '{default: '0};
         vz_ff        <= '{default: '0};
         shade_ff     <= '0;
         bx0_ff       <= '0;
         by0_ff       <= '0;
         bx1_ff       <= '0;
         by1_ff       <= '0;
         col_ff       <= '0;
         row_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         dte_ff       <= dte_in;
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
         clr_ff       <= clr_in;
         step_ff      <= step_in;
         dsel_ff      <= dsel_in;
         bit_ff       <= bit_in;
         vx_ff        <= vx_in;
         vy_ff        <= vy_in;
         vz_ff        <= vz_in;
         shade_ff     <= shade_in;
         bx0_ff       <= bx0_in;
         by0_ff       <= by0_in;
         bx1_ff       <= bx1_in;
         by1_ff       <= by1_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      px_ff   <= px_in;
      py_ff   <= py_in;
      prod_ff <= prod_in;
      a_ff    <= a_in;
      eu_ff   <= eu_in;
      ev_ff   <= ev_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      q_ff    <= q_in;
      neg_ff  <= neg_in;
      u_ff    <= u_in;
      v_ff    <= v_in;
      w_ff    <= w_in;
      zacc_ff <= zacc_in;
      pend_ff <= pend_in;
      rsp_ff  <= rsp_in;
   end

   // an accepted beat always makes the core busy next cycle
   assert property (@(posedge clock) disable iff (reset) accept |=> req_stall)
      else $error("core not busy after accepting a beat");

   // the store is written outside the clearing sweep only with depth testing on
   assert property (@(posedge clock) disable iff (reset)
      (mem_we && state_ff != trdt_pkg::ST_CLEAR) |-> dte_ff)
      else $error("depth store written with depth test off");

   // no request is taken during the clearing sweep
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == trdt_pkg::ST_CLEAR) |-> req_stall)
      else $error("request taken during clear");

   // a response beat is loaded only from the response state
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff) == trdt_pkg::ST_RESP)
      else $error("response raised outside response state");

endmodule

>>> test/triangle_raster_depth_test_core_test.sv
// testbench of the triangle raster depth test core: directed table, random scans, predictor
module triangle_raster_depth_test_core_test;

   localparam int unsigned LIMIT_CYCLES = 4000000;
   localparam int unsigned N_RANDOM     = 1800;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   trdt_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   trdt_pkg::rsp_type rsp_data;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic              csr_data = 1'b0;

   triangle_raster_depth_test_core i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state
   logic               zt_enable;
   logic [11:0]        tri_x [3];
   logic [11:0]        tri_y [3];
   logic signed [15:0] tri_z [3];
   logic [7:0]         tri_shade;
   logic [7:0]         box_x0, box_y0, box_x1, box_y1;
   logic [7:0]         col, row;
   logic               active;
   logic signed [15:0] zbuf [trdt_pkg::STORE_SIZE];

   trdt_pkg::rsp_type pixel_queue [$];
   int      mismatches = 0;
   int      pixels_seen = 0;
   int      pixels_written = 0;
   int      loads_sent = 0;
   longint  cycles = 0;
   bit      idle_en = 1'b1;

   function automatic logic [11:0] min3(logic [11:0] a, logic [11:0] b, logic [11:0] c);
      logic [11:0] m;
      m = a < b ? a : b;
      return m < c ? m : c;
   endfunction

   function automatic logic [11:0] max3(logic [11:0] a, logic [11:0] b, logic [11:0] c);
      logic [11:0] m;
      m = a > b ? a : b;
      return m > c ? m : c;
   endfunction

   // coverage and depth of one pixel
   function automatic bit pixel_cover(logic [7:0] px, logic [7:0] py,
                                      output logic signed [15:0] zo);
      longint x0, y0, dx1, dy1, dx2, dy2, ox, oy, a, eu, ev, u, v, w, s;
      x0 = tri_x[0]; y0 = tri_y[0];
      dx1 = longint'(tri_x[1]) - x0; dy1 = longint'(tri_y[1]) - y0;
      dx2 = longint'(tri_x[2]) - x0; dy2 = longint'(tri_y[2]) - y0;
      ox = x0 - longint'(px) * 16; oy = y0 - longint'(py) * 16;
      a = dx1 * dy2 - dx2 * dy1;
      eu = dx2 * oy - ox * dy2;
      ev = ox * dy1 - dx1 * oy;
      zo = 0;
      if (a > -256 && a < 256) return 0;
      u = (eu * 65536) / a;
      v = (ev * 65536) / a;
      w = 65536 - ((eu + ev) * 65536) / a;
      if (u < 0 || u > 65536 || v < 0 || v > 65536 || w < 0 || w > 65536) return 0;
      s = longint'(tri_z[0]) * w + longint'(tri_z[1]) * u + longint'(tri_z[2]) * v;
      if (s >= 0) s = s / 65536;
      else s = -((-s + 65535) / 65536);
      if (s > 32767) s = 32767;
      if (s < -32768) s = -32768;
      zo = 16'(s);
      return 1;
   endfunction

   // next expected response for one request beat
   function automatic trdt_pkg::rsp_type raster_step(trdt_pkg::req_type r);
      trdt_pkg::rsp_type o;
      logic signed [15:0] z;
      o = '0;
      if (r.func == trdt_pkg::FUNC_LOAD) begin
         tri_x[0] = r.vertex_x0; tri_y[0] = r.vertex_y0; tri_z[0] = r.vertex_z0;
         tri_x[1] = r.vertex_x1; tri_y[1] = r.vertex_y1; tri_z[1] = r.vertex_z1;
         tri_x[2] = r.vertex_x2; tri_y[2] = r.vertex_y2; tri_z[2] = r.vertex_z2;
         tri_shade = r.shade;
         box_x0 = 8'(min3(tri_x[0], tri_x[1], tri_x[2]) >> 4);
         box_y0 = 8'(min3(tri_y[0], tri_y[1], tri_y[2]) >> 4);
         box_x1 = 8'(max3(tri_x[0], tri_x[1], tri_x[2]) >> 4);
         box_y1 = 8'(max3(tri_y[0], tri_y[1], tri_y[2]) >> 4);
         col = box_x0; row = box_y0;
         active = 1'b1;
      end else if (!active) begin
         o.scan_done = 1'b1;
      end else begin
         o.pixel_x = col; o.pixel_y = row; o.pixel_shade = tri_shade;
         if (pixel_cover(col, row, z)) begin
            if (!zt_enable) o.write_pixel = 1'b1;
            else if (zbuf[{row, col}] < z) begin
               zbuf[{row, col}] = z;
               o.write_pixel = 1'b1;
            end
         end
         if (col >= box_x1 && row >= box_y1) begin
            o.scan_done = 1'b1;
            active = 1'b0;
         end else if (col >= box_x1) begin
            col = box_x0;
            row = row + 8'd1;
         end else begin
            col = col + 8'd1;
         end
      end
      return o;
   endfunction

   // directed table, with typed-in result where it is obvious
   typedef struct {
      trdt_pkg::req_type r;
      bit                known;
      trdt_pkg::rsp_type o;
   } vec_type;
   vec_type dir_table [$];

   function automatic trdt_pkg::req_type tri_req(int x0, int y0, int z0, int x1, int y1,
                                                 int z1, int x2, int y2, int z2, int sh);
      trdt_pkg::req_type r;
      r.func = trdt_pkg::FUNC_LOAD;
      r.vertex_x0 = 12'(x0); r.vertex_y0 = 12'(y0); r.vertex_z0 = 16'(z0);
      r.vertex_x1 = 12'(x1); r.vertex_y1 = 12'(y1); r.vertex_z1 = 16'(z1);
      r.vertex_x2 = 12'(x2); r.vertex_y2 = 12'(y2); r.vertex_z2 = 16'(z2);
      r.shade = 8'(sh);
      return r;
   endfunction

   function automatic trdt_pkg::req_type step_req();
      trdt_pkg::req_type r;
      logic [159:0] raw;
      raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
      r = raw[$bits(trdt_pkg::req_type)-1:0];
      r.func = trdt_pkg::FUNC_STEP;
      return r;
   endfunction

   task automatic add_row(trdt_pkg::req_type r, bit known, trdt_pkg::rsp_type o);
      vec_type t;
      t.r = r; t.known = known; t.o = o;
      dir_table.push_back(t);
   endtask

   // request driver with random gaps; valid stays up between back-to-back beats
   task automatic send_req(trdt_pkg::req_type r, bit known, trdt_pkg::rsp_type o);
      trdt_pkg::rsp_type e;
      while (idle_en && $urandom_range(99) < 25) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      e = raster_step(r);
      pixel_queue.push_back(known ? o : e);
      if (r.func == trdt_pkg::FUNC_LOAD) loads_sent++;
      @(negedge clock);
   endtask

   task automatic wait_drain();
      req_valid <= 1'b0;
      while (pixel_queue.size() != 0) @(negedge clock);
      repeat (80) @(negedge clock);
   endtask

   task automatic write_enable(logic val);
      csr_valid <= 1'b1;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      zt_enable = val;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // response stall generator
   always @(negedge clock) begin
      if (!reset) rsp_stall <= idle_en && ($urandom_range(99) < 25);
   end

   // response checker
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset && rsp_valid && !rsp_stall) begin
         trdt_pkg::rsp_type e;
         pixels_seen <= pixels_seen + 1;
         if (rsp_data.write_pixel) pixels_written <= pixels_written + 1;
         if (pixel_queue.size() == 0) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10) $display("unexpected response beat %h", rsp_data);
         end else begin
            e = pixel_queue.pop_front();
            if (rsp_data !== e) begin
               mismatches <= mismatches + 1;
               if (mismatches < 10)
                  $display("mismatch: exp wr=%0b x=%0d y=%0d sh=%0d done=%0b %s",
                           e.write_pixel, e.pixel_x, e.pixel_y, e.pixel_shade,
                           e.scan_done,
                           $sformatf("got wr=%0b x=%0d y=%0d sh=%0d done=%0b",
                                     rsp_data.write_pixel, rsp_data.pixel_x,
                                     rsp_data.pixel_y, rsp_data.pixel_shade,
                                     rsp_data.scan_done));
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (cycles > LIMIT_CYCLES) begin
         $display("timeout with %0d beats still expected", pixel_queue.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // random triangle, mostly small so scans stay short
   function automatic trdt_pkg::req_type rand_tri();
      trdt_pkg::req_type r;
      logic [159:0] raw;
      int bx, by, span;
      raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
      r = raw[$bits(trdt_pkg::req_type)-1:0];
      r.func = trdt_pkg::FUNC_LOAD;
      if ($urandom_range(9) < 8) begin
         span = $urandom_range(1, 6) * 16;
         bx = $urandom_range(0, 4095 - span);
         by = $urandom_range(0, 4095 - span);
         if ($urandom_range(3) == 0) begin
            bx = $urandom_range(0, 200 * 16);
            by = $urandom_range(0, 200 * 16);
         end
         r.vertex_x0 = 12'(bx + $urandom_range(0, span));
         r.vertex_y0 = 12'(by + $urandom_range(0, span));
         r.vertex_x1 = 12'(bx + $urandom_range(0, span));
         r.vertex_y1 = 12'(by + $urandom_range(0, span));
         r.vertex_x2 = 12'(bx + $urandom_range(0, span));
         r.vertex_y2 = 12'(by + $urandom_range(0, span));
      end
      return r;
   endfunction

   initial begin
      trdt_pkg::rsp_type zero_rsp, idle_rsp;
      int n;
      int box;
      zero_rsp = '0;
      idle_rsp = '0;
      idle_rsp.scan_done = 1'b1;
      zt_enable = 1'b1;
      active = 1'b0;
      tri_shade = '0;
      box_x0 = '0; box_y0 = '0; box_x1 = '0; box_y1 = '0; col = '0; row = '0;
      for (int i = 0; i < 3; i++) begin
         tri_x[i] = '0; tri_y[i] = '0; tri_z[i] = '0;
      end
      for (int i = 0; i < trdt_pkg::STORE_SIZE; i++) zbuf[i] = trdt_pkg::DEPTH_FLOOR;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: idle step, extreme triangles, degenerate, screen corner, reload mid-scan
      add_row(step_req(), 1, idle_rsp);
      add_row(tri_req(0, 0, 32767, 32, 0, 32767, 0, 32, 32767, 255), 1, zero_rsp);
      for (int i = 0; i < 9; i++) add_row(step_req(), 0, zero_rsp);
      add_row(tri_req(0, 0, -32768, 32, 0, -32768, 0, 32, -32768, 0), 1, zero_rsp);
      for (int i = 0; i < 4; i++) add_row(step_req(), 0, zero_rsp);
      add_row(tri_req(4095, 4095, 1, 4064, 4095, 2, 4095, 4064, 3, 170), 1, zero_rsp);
      for (int i = 0; i < 3; i++) add_row(step_req(), 0, zero_rsp);
      add_row(tri_req(16, 16, 100, 48, 48, 100, 80, 80, 100, 85), 1, zero_rsp);
      for (int i = 0; i < 3; i++) add_row(step_req(), 0, zero_rsp);
      foreach (dir_table[i]) send_req(dir_table[i].r, dir_table[i].known, dir_table[i].o);
      wait_drain();

      // depth test off, one triangle over pixels already drawn, scanned in full
      write_enable(1'b0);
      send_req(tri_req(0, 0, 5, 48, 0, 5, 0, 48, 5, 1), 1, zero_rsp);
      repeat (16) send_req(step_req(), 0, zero_rsp);
      wait_drain();
      write_enable(1'b1);

      // random: scans of random triangles with noise and broken scans
      n = 0;
      while (n < N_RANDOM) begin
         if (n > 600 && n < 900) idle_en = 1'b0;
         else idle_en = 1'b1;
         if (n > 1200 && n < 1220) begin
            wait_drain();
            write_enable(n[0]);
         end
         send_req(rand_tri(), 0, zero_rsp);
         n++;
         box = 0;
         if ($urandom_range(9) == 0) box = $urandom_range(0, 5);
         else box = 200;
         while (active && box > 0 && n < N_RANDOM) begin
            send_req(step_req(), 0, zero_rsp);
            n++;
            box--;
         end
         if ($urandom_range(7) == 0) begin
            send_req(step_req(), 0, zero_rsp);
            n++;
         end
         if (n > 1400 && n < 1410) wait_drain();
      end
      idle_en = 1'b1;
      wait_drain();
      write_enable(1'b1);

      $display("covered %0d triangle loads, %0d response beats, %0d pixels written",
               loads_sent, pixels_seen, pixels_written);
      if (mismatches == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("%0d mismatches in all", mismatches);
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
